### sv/rotated_quad_vertex_gen_assert.svh
// Assertion macros used by the checker module of this block.
`ifndef ROTATED_QUAD_VERTEX_GEN_ASSERT_SVH
`define ROTATED_QUAD_VERTEX_GEN_ASSERT_SVH

// Checked on every rising edge of clk, suspended while arst_n is low.
`define RQVG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define RQVG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rqvg_pkg.sv
package rqvg_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
	localparam int TAB_IDX_W = SINE_TABLE_BITS - 1;
	localparam real PI_HALF = 1.5707963267948966;
	localparam real SINE_STEP_RAD = PI_HALF / real'(QUARTER);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic REG_BOX_WIDTH = 1'b0;
	localparam logic REG_BOX_HEIGHT = 1'b1;

	typedef logic [14:0] sine_tab_t [0:QUARTER];

	// Quarter wave of round(32767 * sin), evaluated once at elaboration.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		real x;
		for (int i = 0; i <= QUARTER; i++) begin
			x = 32767.0 * $sin(SINE_STEP_RAD * real'(i));
			tab[i] = 15'($rtoi(x + 0.5));
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] sin_v;
		logic signed [15:0] cos_v;
	} trig_t;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [17:0] a;
		logic signed [17:0] b;
		logic signed [17:0] c;
		logic signed [17:0] d;
	} offset_t;

	typedef struct packed {
		logic [15:0] c3_y;
		logic [15:0] c3_x;
		logic [15:0] c2_y;
		logic [15:0] c2_x;
		logic [15:0] c1_y;
		logic [15:0] c1_x;
		logic [15:0] c0_y;
		logic [15:0] c0_x;
		logic        clipped;
	} corners_t;

endpackage

### sv/rqvg_sincos.sv
module rqvg_sincos (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_in,
	input  logic signed [15:0]     centre_x,
	input  logic signed [15:0]     centre_y,
	input  logic [15:0]            rotation,
	output logic                   vld_s1,
	output rqvg_pkg::trig_t        trig_s1
);

	logic [rqvg_pkg::SINE_TABLE_BITS-1:0] k;
	logic [1:0]                            quad_s;
	logic [1:0]                            quad_c;
	logic [rqvg_pkg::TAB_IDX_W-1:0]        r;
	logic [rqvg_pkg::TAB_IDX_W-1:0]        r_mirror;
	logic [rqvg_pkg::TAB_IDX_W-1:0]        idx_s;
	logic [rqvg_pkg::TAB_IDX_W-1:0]        idx_c;
	logic signed [15:0]                    mag_s;
	logic signed [15:0]                    mag_c;

	assign k = rotation[15 -: rqvg_pkg::SINE_TABLE_BITS];
	assign quad_s = k[rqvg_pkg::SINE_TABLE_BITS-1 -: 2];
	assign quad_c = quad_s + 2'd1;
	assign r = rqvg_pkg::TAB_IDX_W'(k[rqvg_pkg::SINE_TABLE_BITS-3:0]);
	assign r_mirror = rqvg_pkg::TAB_IDX_W'(rqvg_pkg::QUARTER) - r;
	assign idx_s = quad_s[0] ? r_mirror : r;
	assign idx_c = quad_c[0] ? r_mirror : r;
	assign mag_s = $signed({1'b0, rqvg_pkg::SINE_TAB[idx_s]});
	assign mag_c = $signed({1'b0, rqvg_pkg::SINE_TAB[idx_c]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s1.px <= centre_x;
			trig_s1.py <= centre_y;
			trig_s1.sin_v <= quad_s[1] ? -mag_s : mag_s;
			trig_s1.cos_v <= quad_c[1] ? -mag_c : mag_c;
		end
	end

endmodule

### sv/rqvg_offset.sv
module rqvg_offset (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_s1,
	input  rqvg_pkg::trig_t        trig_s1,
	input  logic [15:0]            box_width,
	input  logic [15:0]            box_height,
	output logic                   vld_s3,
	output rqvg_pkg::offset_t      ofs_s3
);

	logic signed [15:0] hw;
	logic signed [15:0] hh;
	logic signed [31:0] p_shh;
	logic signed [31:0] p_chw;
	logic signed [31:0] p_chh;
	logic signed [31:0] p_shw;

	logic               vld_s2;
	logic signed [15:0] px_s2;
	logic signed [15:0] py_s2;
	logic signed [16:0] shh_s2;
	logic signed [16:0] chw_s2;
	logic signed [16:0] chh_s2;
	logic signed [16:0] shw_s2;

	assign hw = $signed({1'b0, box_width[15:1]});
	assign hh = $signed({1'b0, box_height[15:1]});
	assign p_shh = trig_s1.sin_v * hh;
	assign p_chw = trig_s1.cos_v * hw;
	assign p_chh = trig_s1.cos_v * hh;
	assign p_shw = trig_s1.sin_v * hw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Dropping the low 15 bits of a two's complement product rounds toward minus infinity.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= trig_s1.px;
			py_s2 <= trig_s1.py;
			shh_s2 <= p_shh[31:15];
			chw_s2 <= p_chw[31:15];
			chh_s2 <= p_chh[31:15];
			shw_s2 <= p_shw[31:15];

			ofs_s3.px <= px_s2;
			ofs_s3.py <= py_s2;
			ofs_s3.a <= 18'(shh_s2) + 18'(chw_s2);
			ofs_s3.b <= 18'(chh_s2) - 18'(shw_s2);
			ofs_s3.c <= 18'(shh_s2) - 18'(chw_s2);
			ofs_s3.d <= 18'(chh_s2) + 18'(shw_s2);
		end
	end

endmodule

### sv/rqvg_corner.sv
module rqvg_corner (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_s3,
	input  rqvg_pkg::offset_t      ofs_s3,
	output logic                   vld_s4,
	output rqvg_pkg::corners_t     crn_s4
);

	logic signed [18:0] raw [8];
	logic [15:0]        sat [8];
	logic [7:0]         clip;
	logic signed [18:0] px_w;
	logic signed [18:0] py_w;

	assign px_w = 19'(ofs_s3.px);
	assign py_w = 19'(ofs_s3.py);
	assign raw[0] = px_w - 19'(ofs_s3.a);
	assign raw[1] = py_w - 19'(ofs_s3.b);
	assign raw[2] = px_w - 19'(ofs_s3.c);
	assign raw[3] = py_w - 19'(ofs_s3.d);
	assign raw[4] = px_w + 19'(ofs_s3.c);
	assign raw[5] = py_w + 19'(ofs_s3.d);
	assign raw[6] = px_w + 19'(ofs_s3.a);
	assign raw[7] = py_w + 19'(ofs_s3.b);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (raw[i] > 19'sd32767) begin
				sat[i] = 16'h7fff;
				clip[i] = 1'b1;
			end else if (raw[i] < -19'sd32768) begin
				sat[i] = 16'h8000;
				clip[i] = 1'b1;
			end else begin
				sat[i] = raw[i][15:0];
				clip[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crn_s4.c0_x <= sat[0];
			crn_s4.c0_y <= sat[1];
			crn_s4.c1_x <= sat[2];
			crn_s4.c1_y <= sat[3];
			crn_s4.c2_x <= sat[4];
			crn_s4.c2_y <= sat[5];
			crn_s4.c3_x <= sat[6];
			crn_s4.c3_y <= sat[7];
			crn_s4.clipped <= |clip;
		end
	end

endmodule

### sv/rotated_quad_vertex_gen.sv
// Rotated rectangle corner generator.
// Input stream: s_axis_tdata carries one sprite per transaction, a signed Q12.4
// centre and a 16-bit binary angle. Output stream: m_axis_tdata carries the four
// rotated corners in signed Q12.4, and m_axis_tuser flags a saturated coordinate.
// Box width and height are set through the APB port at byte addresses 0 and 4 and
// should only be written while no transaction is in flight.
// The datapath is a four stage pipeline: sine and cosine lookup, the four products,
// the offset sums, and the corner add with saturation. An accepted transaction passes
// through the stage registers s1, s2, s3 and s4 in order, and s4 presents its result.
// Throughput is one transaction per cycle, set by the single pipeline, while the
// receiver does not hold m_axis_tready low.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops in the same cycle, so nothing is lost
// or repeated. Reset clears all stage valid bits and both size registers.
module rotated_quad_vertex_gen (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rqvg_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [rqvg_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [rqvg_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// centre_x, centre_y, rotation
	input  logic [47:0]                      s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
	output logic [127:0]                     m_axis_tdata,
	// clipped
	output logic [0:0]                       m_axis_tuser
);

	logic [15:0]         box_width_q;
	logic [15:0]         box_height_q;
	logic                en;
	logic                vld_s1;
	logic                vld_s3;
	logic                vld_s4;
	rqvg_pkg::trig_t     trig_s1;
	rqvg_pkg::offset_t   ofs_s3;
	rqvg_pkg::corners_t  crn_s4;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_width_q <= '0;
			box_height_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == rqvg_pkg::REG_BOX_HEIGHT) begin
				box_height_q <= pwdata[15:0];
			end else begin
				box_width_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = (paddr[2] == rqvg_pkg::REG_BOX_WIDTH) ?
		{16'd0, box_width_q} : {16'd0, box_height_q};

	assign en = !vld_s4 || m_axis_tready;
	assign s_axis_tready = en;

	rqvg_sincos u_sincos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (s_axis_tvalid),
		.centre_x ($signed(s_axis_tdata[15:0])),
		.centre_y ($signed(s_axis_tdata[31:16])),
		.rotation (s_axis_tdata[47:32]),
		.vld_s1   (vld_s1),
		.trig_s1  (trig_s1)
	);

	rqvg_offset u_offset (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_s1     (vld_s1),
		.trig_s1    (trig_s1),
		.box_width  (box_width_q),
		.box_height (box_height_q),
		.vld_s3     (vld_s3),
		.ofs_s3     (ofs_s3)
	);

	rqvg_corner u_corner (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_s3 (vld_s3),
		.ofs_s3 (ofs_s3),
		.vld_s4 (vld_s4),
		.crn_s4 (crn_s4)
	);

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata = {crn_s4.c3_y, crn_s4.c3_x, crn_s4.c2_y, crn_s4.c2_x,
		crn_s4.c1_y, crn_s4.c1_x, crn_s4.c0_y, crn_s4.c0_x};
	assign m_axis_tuser = crn_s4.clipped;

endmodule

### sv/rqvg_checker.sv
`include "rotated_quad_vertex_gen_assert.svh"

module rqvg_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [127:0] m_axis_tdata,
	input  logic [0:0]   m_axis_tuser
);

	logic signed [16:0] sum03_x;
	logic signed [16:0] sum12_x;
	logic signed [16:0] sum03_y;
	logic signed [16:0] sum12_y;

	// Without saturation, opposite corners average to the centre in both pairs.
	assign sum03_x = 17'($signed(m_axis_tdata[15:0])) + 17'($signed(m_axis_tdata[111:96]));
	assign sum12_x = 17'($signed(m_axis_tdata[47:32])) + 17'($signed(m_axis_tdata[79:64]));
	assign sum03_y = 17'($signed(m_axis_tdata[31:16])) + 17'($signed(m_axis_tdata[127:112]));
	assign sum12_y = 17'($signed(m_axis_tdata[63:48])) + 17'($signed(m_axis_tdata[95:80]));

	`RQVG_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output transaction dropped while stalled")
	`RQVG_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled output data changed")
	`RQVG_ASSERT_ALWAYS(a_ready_flow, !arst_n || (s_axis_tready == (!m_axis_tvalid || m_axis_tready)), "input ready does not follow output stall")
	`RQVG_ASSERT(a_symmetry, m_axis_tvalid && !m_axis_tuser[0] |-> (sum03_x == sum12_x) && (sum03_y == sum12_y), "unclipped corners are not centered")

endmodule

bind rotated_quad_vertex_gen rqvg_checker u_rqvg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
